// ===== rtl/tmq_pkg.sv =====
// Shared types and constants of the timer expiry queue.
package tmq_pkg;

  localparam int TIME_W = 63;
  localparam int ID_W   = 4;
  localparam int OP_W   = 2;

  typedef logic [TIME_W-1:0] tmq_time_t;

  typedef enum logic [OP_W-1:0] {
    OP_ARM    = 2'd0,
    OP_CANCEL = 2'd1,
    OP_TICK   = 2'd2
  } tmq_op_t;

  typedef struct packed {
    logic            fired;
    logic [ID_W-1:0] fired_id;
    logic            next_valid;
    tmq_time_t       next_deadline;
    logic            last;
  } tmq_result_t;

endpackage

// ===== rtl/timer_expiry_queue.sv =====
// Top level of the timer expiry queue: request decode, slot state and result register.
//
// Channel   Direction  Handshake             Payload
// req       input      req_valid/req_stall   operation, timer_id, delay_ticks, now_time
// rsp       output     rsp_valid/rsp_stall   fired, fired_id, next_valid, next_deadline, last
//
// An arm or cancel transaction yields no result and does not hold the request port.
// A tick that fires k slots yields k + 1 results: each result comes from one full pass of
// the expiry memory read port, one slot per cycle, followed by a drain, a decide and an
// emit state.
// Reset clears the armed bits, the current time and all handshake state; the expiry
// memory is not cleared, since an entry is only looked at while its slot is armed.
// A stall on rsp holds the sequencer in its emit state; a new request is still taken
// while the final status result of a tick waits in the output register.
module timer_expiry_queue #(
  parameter int NUM_TIMERS = 16
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  req_valid,
  output logic                  req_stall,
  input  logic [tmq_pkg::OP_W-1:0] operation,
  input  logic [tmq_pkg::ID_W-1:0] timer_id,
  input  tmq_pkg::tmq_time_t    delay_ticks,
  input  tmq_pkg::tmq_time_t    now_time,
  output logic                  rsp_valid,
  input  logic                  rsp_stall,
  output logic                  fired,
  output logic [tmq_pkg::ID_W-1:0] fired_id,
  output logic                  next_valid,
  output tmq_pkg::tmq_time_t    next_deadline,
  output logic                  last
);
  import tmq_pkg::*;

  localparam int IDX_W = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;

  logic [NUM_TIMERS-1:0] armed;
  tmq_time_t             current_time;

  logic                  accept;
  tmq_op_t               op;
  logic [8:0]            id_wide;
  logic                  id_ok;
  logic [IDX_W-1:0]      widx;
  logic [TIME_W:0]       sum;
  tmq_time_t             expiry_next;
  logic                  arm_we;
  logic                  start;

  logic [IDX_W-1:0]      raddr;
  tmq_time_t             rdata;
  logic                  busy;
  tmq_result_t           res;
  logic                  res_valid;
  logic                  res_take;
  logic [IDX_W-1:0]      best_idx;

  // Only one request is worked on at a time; a tick keeps the port stalled until its
  // status result has moved into the output register.
  assign req_stall = busy;
  assign accept    = req_valid && !req_stall;
  assign op        = tmq_op_t'(operation);

  // Slot ids at or above NUM_TIMERS are ignored by arm and cancel.
  assign id_wide = 9'(timer_id);
  assign id_ok   = id_wide < 9'(NUM_TIMERS);
  assign widx    = id_wide[IDX_W-1:0];

  // Both operands are below 2^63, so the carry out alone tells of saturation.
  assign sum         = {1'b0, current_time} + {1'b0, delay_ticks};
  assign expiry_next = sum[TIME_W] ? {TIME_W{1'b1}} : sum[TIME_W-1:0];

  assign arm_we = accept && (op == OP_ARM) && id_ok;
  assign start  = accept && (op == OP_TICK);

  // A result moves to the output register when the register is empty or being emptied.
  assign res_take = res_valid && (!rsp_valid || !rsp_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      armed        <= '0;
      current_time <= '0;
    end else begin
      if (accept) begin
        case (op)
          OP_ARM: begin
            if (id_ok) begin
              armed[widx] <= 1'b1;
            end
          end
          OP_CANCEL: begin
            if (id_ok) begin
              armed[widx] <= 1'b0;
            end
          end
          OP_TICK: begin
            current_time <= now_time;
          end
          default: begin
          end
        endcase
      end
      // A fired slot is disarmed as its result leaves, before the next pass starts.
      if (res_take && res.fired) begin
        armed[best_idx] <= 1'b0;
      end
    end
  end

  tmq_expiry_ram #(
    .DEPTH  (NUM_TIMERS),
    .ADDR_W (IDX_W)
  ) u_ram (
    .clk   (clk),
    .we    (arm_we),
    .waddr (widx),
    .wdata (expiry_next),
    .raddr (raddr),
    .rdata (rdata)
  );

  tmq_scan #(
    .NUM_TIMERS (NUM_TIMERS),
    .IDX_W      (IDX_W)
  ) u_scan (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .now       (now_time),
    .armed     (armed),
    .raddr     (raddr),
    .rdata     (rdata),
    .busy      (busy),
    .res       (res),
    .res_valid (res_valid),
    .res_take  (res_take),
    .best_idx  (best_idx)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (res_take) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_take) begin
      fired         <= res.fired;
      fired_id      <= res.fired_id;
      next_valid    <= res.next_valid;
      next_deadline <= res.next_deadline;
      last          <= res.last;
    end
  end

  property p_fire_armed_slot;
    @(posedge clk) disable iff (rst) (res_take && res.fired) |-> armed[best_idx];
  endproperty
  a_fire_armed_slot: assert property (p_fire_armed_slot)
    else $error("fired result for a slot that is not armed");

  property p_tick_never_arms;
    @(posedge clk) disable iff (rst)
      (busy && $past(busy)) |-> ($countones(armed) <= $past($countones(armed)));
  endproperty
  a_tick_never_arms: assert property (p_tick_never_arms)
    else $error("armed slot count grew during a tick");

  property p_fired_is_not_status;
    @(posedge clk) disable iff (rst) (res_take && res.fired) |-> (!res.last && !res.next_valid);
  endproperty
  a_fired_is_not_status: assert property (p_fired_is_not_status)
    else $error("fired result carries status fields");

endmodule

// ===== rtl/tmq_expiry_ram.sv =====
// Expiry time memory: one write port, one read port with registered read data.
module tmq_expiry_ram #(
  parameter int DEPTH  = 16,
  parameter int ADDR_W = 4
) (
  input  logic                clk,
  input  logic                we,
  input  logic [ADDR_W-1:0]   waddr,
  input  tmq_pkg::tmq_time_t  wdata,
  input  logic [ADDR_W-1:0]   raddr,
  output tmq_pkg::tmq_time_t  rdata
);
  import tmq_pkg::*;

  tmq_time_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/tmq_scan.sv =====
// Tick sequencer: scans the expiry memory for the earliest armed slot and builds results.
module tmq_scan #(
  parameter int NUM_TIMERS = 16,
  parameter int IDX_W      = 4
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  tmq_pkg::tmq_time_t   now,
  input  logic [NUM_TIMERS-1:0] armed,
  output logic [IDX_W-1:0]     raddr,
  input  tmq_pkg::tmq_time_t   rdata,
  output logic                 busy,
  output tmq_pkg::tmq_result_t res,
  output logic                 res_valid,
  input  logic                 res_take,
  output logic [IDX_W-1:0]     best_idx
);
  import tmq_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_DRAIN,
    S_DECIDE,
    S_EMIT
  } state_t;

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_TIMERS - 1);

  state_t           state;
  logic [IDX_W-1:0] cnt;
  logic             pend_vld;
  logic [IDX_W-1:0] pend_idx;
  logic             best_found;
  tmq_time_t        best_exp;
  tmq_time_t        now_r;
  logic             hit;
  logic [8:0]       best_wide;

  // The entry read last cycle replaces the best one if it is armed and strictly earlier.
  assign hit       = pend_vld && armed[pend_idx] && (!best_found || (rdata < best_exp));
  assign raddr     = cnt;
  assign busy      = (state != S_IDLE);
  assign best_wide = 9'(best_idx);

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      cnt        <= '0;
      pend_vld   <= 1'b0;
      best_found <= 1'b0;
      res_valid  <= 1'b0;
    end else begin
      pend_vld <= 1'b0;
      if (hit) begin
        best_found <= 1'b1;
        best_idx   <= pend_idx;
        best_exp   <= rdata;
      end
      case (state)
        S_IDLE: begin
          if (start) begin
            now_r      <= now;
            cnt        <= '0;
            best_found <= 1'b0;
            state      <= S_SCAN;
          end
        end
        S_SCAN: begin
          pend_vld <= 1'b1;
          pend_idx <= cnt;
          if (cnt == LAST_IDX) begin
            state <= S_DRAIN;
          end else begin
            cnt <= cnt + 1'b1;
          end
        end
        S_DRAIN: begin
          state <= S_DECIDE;
        end
        S_DECIDE: begin
          res_valid <= 1'b1;
          if (best_found && (best_exp <= now_r)) begin
            res.fired         <= 1'b1;
            res.fired_id      <= best_wide[ID_W-1:0];
            res.next_valid    <= 1'b0;
            res.next_deadline <= '0;
            res.last          <= 1'b0;
          end else begin
            res.fired         <= 1'b0;
            res.fired_id      <= '0;
            res.next_valid    <= best_found;
            res.next_deadline <= best_found ? best_exp : '0;
            res.last          <= 1'b1;
          end
          state <= S_EMIT;
        end
        S_EMIT: begin
          if (res_take) begin
            res_valid <= 1'b0;
            if (res.last) begin
              state <= S_IDLE;
            end else begin
              cnt        <= '0;
              best_found <= 1'b0;
              state      <= S_SCAN;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  property p_result_only_in_emit;
    @(posedge clk) disable iff (rst) res_valid |-> (state == S_EMIT);
  endproperty
  a_result_only_in_emit: assert property (p_result_only_in_emit)
    else $error("scan result valid outside the emit state");

  property p_fired_beats_now;
    @(posedge clk) disable iff (rst) (res_valid && res.fired) |-> (best_exp <= now_r);
  endproperty
  a_fired_beats_now: assert property (p_fired_beats_now)
    else $error("fired slot expires after the tick time");

  property p_status_then_idle;
    @(posedge clk) disable iff (rst) (res_take && res.last) |=> !busy;
  endproperty
  a_status_then_idle: assert property (p_status_then_idle)
    else $error("tick did not finish after its status result");

endmodule

// ===== tb/timer_expiry_queue_checker.sv =====
// Checker for the timer expiry queue: it watches both channels, predicts results and compares them.
`timescale 1ns / 100ps
module timer_expiry_queue_checker #(
  parameter int NUM_TIMERS = 16
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        req_valid,
  input  logic                        req_stall,
  input  logic [tmq_pkg::OP_W-1:0]    operation,
  input  logic [tmq_pkg::ID_W-1:0]    timer_id,
  input  tmq_pkg::tmq_time_t          delay_ticks,
  input  tmq_pkg::tmq_time_t          now_time,
  input  logic                        rsp_valid,
  input  logic                        rsp_stall,
  input  logic                        fired,
  input  logic [tmq_pkg::ID_W-1:0]    fired_id,
  input  logic                        next_valid,
  input  tmq_pkg::tmq_time_t          next_deadline,
  input  logic                        last,
  input  logic                        end_check,
  output int                          pending,
  output int                          fail_count,
  output int                          request_total,
  output int                          tick_total,
  output int                          fired_total,
  output int                          most_fired
);
  import tmq_pkg::*;

  localparam int SHOW_LIMIT = 10;

  logic        slot_live     [NUM_TIMERS];
  tmq_time_t   slot_deadline [NUM_TIMERS];
  tmq_time_t   model_time;
  tmq_result_t expected_results [$];
  int          mismatches;
  int          requests_seen;
  int          ticks_seen;
  int          fires_seen;
  int          fires_peak;
  bit          leftover_done;

  // Earliest armed slot, ties going to the lower id; -1 when nothing is armed.
  function automatic int earliest_slot();
    int best;
    best = -1;
    for (int i = 0; i < NUM_TIMERS; i++) begin
      if (slot_live[i] && (best < 0 || slot_deadline[i] < slot_deadline[best])) begin
        best = i;
      end
    end
    return best;
  endfunction

  task automatic arm_slot(input logic [ID_W-1:0] id, input tmq_time_t dly);
    logic [TIME_W:0] sum;
    sum = {1'b0, model_time} + {1'b0, dly};
    if (int'(id) < NUM_TIMERS) begin
      slot_deadline[id] = sum[TIME_W] ? {TIME_W{1'b1}} : sum[TIME_W-1:0];
      slot_live[id]     = 1'b1;
    end
  endtask

  task automatic predict_tick(input tmq_time_t now_v);
    int          best;
    int          fired_here;
    tmq_result_t r;
    fired_here = 0;
    model_time = now_v;
    best = earliest_slot();
    while (best >= 0 && slot_deadline[best] <= now_v) begin
      slot_live[best] = 1'b0;
      r = '0;
      r.fired = 1'b1;
      r.fired_id = ID_W'(best);
      expected_results.push_back(r);
      fired_here++;
      best = earliest_slot();
    end
    r = '0;
    r.last = 1'b1;
    if (best >= 0) begin
      r.next_valid = 1'b1;
      r.next_deadline = slot_deadline[best];
    end
    expected_results.push_back(r);
    ticks_seen++;
    fires_seen += fired_here;
    if (fired_here > fires_peak) fires_peak = fired_here;
  endtask

  task automatic check_result(input tmq_result_t got);
    tmq_result_t want;
    if (expected_results.size() == 0) begin
      mismatches++;
      if (mismatches <= SHOW_LIMIT) begin
        $display("%0t: unexpected result fired=%0d id=%0d next_valid=%0d deadline=%0d last=%0d",
                 $time, got.fired, got.fired_id, got.next_valid, got.next_deadline, got.last);
      end
      return;
    end
    want = expected_results.pop_front();
    if (got.fired !== want.fired || got.fired_id !== want.fired_id ||
        got.next_valid !== want.next_valid || got.next_deadline !== want.next_deadline ||
        got.last !== want.last) begin
      mismatches++;
      if (mismatches <= SHOW_LIMIT) begin
        $display("%0t: result mismatch", $time);
        $display("  expected fired=%0d id=%0d next_valid=%0d deadline=%0d last=%0d",
                 want.fired, want.fired_id, want.next_valid, want.next_deadline, want.last);
        $display("  actual   fired=%0d id=%0d next_valid=%0d deadline=%0d last=%0d",
                 got.fired, got.fired_id, got.next_valid, got.next_deadline, got.last);
      end
    end
  endtask

  always @(posedge clk) begin
    tmq_result_t got;
    if (rst) begin
      for (int i = 0; i < NUM_TIMERS; i++) begin
        slot_live[i] = 1'b0;
        slot_deadline[i] = '0;
      end
      model_time = '0;
      expected_results.delete();
      mismatches = 0;
      requests_seen = 0;
      ticks_seen = 0;
      fires_seen = 0;
      fires_peak = 0;
      leftover_done = 1'b0;
    end else begin
      // Results come first: a result never belongs to a request taken at the same edge.
      if (rsp_valid && !rsp_stall) begin
        got.fired = fired;
        got.fired_id = fired_id;
        got.next_valid = next_valid;
        got.next_deadline = next_deadline;
        got.last = last;
        check_result(got);
      end
      if (req_valid && !req_stall) begin
        requests_seen++;
        case (operation)
          OP_ARM:    arm_slot(timer_id, delay_ticks);
          OP_CANCEL: if (int'(timer_id) < NUM_TIMERS) slot_live[timer_id] = 1'b0;
          OP_TICK:   predict_tick(now_time);
          default:   ;
        endcase
      end
      if (end_check && !leftover_done) begin
        leftover_done = 1'b1;
        if (expected_results.size() != 0) begin
          $display("%0t: %0d expected results never arrived", $time, expected_results.size());
          mismatches += expected_results.size();
        end
      end
    end
    pending <= expected_results.size();
    fail_count <= mismatches;
    request_total <= requests_seen;
    tick_total <= ticks_seen;
    fired_total <= fires_seen;
    most_fired <= fires_peak;
  end

endmodule

// ===== tb/timer_expiry_queue_tb.sv =====
// Testbench top for the timer expiry queue: clock, reset, stimulus, result sink and verdict.
`timescale 1ns / 100ps
module timer_expiry_queue_tb;
  import tmq_pkg::*;

  localparam int NUM_SLOTS = 16;
  // Operation code that the block must ignore.
  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
  localparam tmq_time_t TIME_MAX = '1;
  localparam int RANDOM_ITEMS = 110;
  // One full scan of the slots, taken twice, covers the tail of a tick.
  localparam int SETTLE_CYCLES = 2 * (NUM_SLOTS + 3);
  // The long receiver hold-off, and the watchdog well above it.
  localparam int LONG_HOLD = 300;
  localparam int WATCHDOG_LIMIT = 4000;

  logic                clk;
  logic                rst;
  logic                req_valid;
  logic                req_stall;
  logic [OP_W-1:0]     operation;
  logic [ID_W-1:0]     timer_id;
  tmq_time_t           delay_ticks;
  tmq_time_t           now_time;
  logic                rsp_valid;
  logic                rsp_stall;
  logic                fired;
  logic [ID_W-1:0]     fired_id;
  logic                next_valid;
  tmq_time_t           next_deadline;
  logic                last;
  logic                end_check;

  int pending;
  int fail_count;
  int request_total;
  int tick_total;
  int fired_total;
  int most_fired;

  // Stimulus-side bookkeeping. stim_time follows the last tick sent so that most ticks
  // land a little after the deadlines that were just armed.
  tmq_time_t stim_time;
  int        items_sent;
  bit        no_gap;
  bit        hold_req;

  timer_expiry_queue #(
    .NUM_TIMERS(NUM_SLOTS)
  ) dut (
    .clk(clk),
    .rst(rst),
    .req_valid(req_valid),
    .req_stall(req_stall),
    .operation(operation),
    .timer_id(timer_id),
    .delay_ticks(delay_ticks),
    .now_time(now_time),
    .rsp_valid(rsp_valid),
    .rsp_stall(rsp_stall),
    .fired(fired),
    .fired_id(fired_id),
    .next_valid(next_valid),
    .next_deadline(next_deadline),
    .last(last)
  );

  timer_expiry_queue_checker #(
    .NUM_TIMERS(NUM_SLOTS)
  ) u_checker (
    .clk(clk),
    .rst(rst),
    .req_valid(req_valid),
    .req_stall(req_stall),
    .operation(operation),
    .timer_id(timer_id),
    .delay_ticks(delay_ticks),
    .now_time(now_time),
    .rsp_valid(rsp_valid),
    .rsp_stall(rsp_stall),
    .fired(fired),
    .fired_id(fired_id),
    .next_valid(next_valid),
    .next_deadline(next_deadline),
    .last(last),
    .end_check(end_check),
    .pending(pending),
    .fail_count(fail_count),
    .request_total(request_total),
    .tick_total(tick_total),
    .fired_total(fired_total),
    .most_fired(most_fired)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // A random 63-bit value whose magnitude is spread over the whole range, so that every
  // bit of a time field is seen at both values while small values stay common.
  function automatic tmq_time_t wide_time();
    logic [63:0] raw;
    raw = {$urandom, $urandom};
    return tmq_time_t'(raw >> $urandom_range(0, 62));
  endfunction

  // Arm delays are mostly short so that ticks fire them; a few are huge or saturate.
  function automatic tmq_time_t pick_delay();
    case ($urandom_range(0, 15))
      0:       return TIME_MAX;
      1, 2:    return wide_time();
      default: return tmq_time_t'($urandom_range(0, 200));
    endcase
  endfunction

  // A time a given step after the last tick, held at the top of the time range.
  function automatic tmq_time_t later(input tmq_time_t step);
    logic [TIME_W:0] sum;
    sum = {1'b0, stim_time} + {1'b0, step};
    return sum[TIME_W] ? TIME_MAX : sum[TIME_W-1:0];
  endfunction

  // Offers one request transaction and holds it until it is taken. After acceptance the
  // sender draws its gap; with no gap, valid simply stays high for the next transaction,
  // so valid is never lowered and raised in the same time step.
  task automatic send_request(input logic [OP_W-1:0] op, input logic [ID_W-1:0] id,
                              input tmq_time_t dly, input tmq_time_t now_v);
    int gap;
    req_valid <= 1'b1;
    operation <= op;
    timer_id <= id;
    delay_ticks <= dly;
    now_time <= now_v;
    do @(posedge clk); while (req_stall);
    if (op == OP_TICK) stim_time = now_v;
    // A request with the unused code is ignored by the block and does not count.
    if (op != OP_UNUSED) items_sent++;
    gap = no_gap ? 0 : $urandom_range(0, 15);
    if (gap > 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Fields that an operation does not use still get random values.
  task automatic arm_timer(input logic [ID_W-1:0] id, input tmq_time_t dly);
    send_request(OP_ARM, id, dly, wide_time());
  endtask

  task automatic cancel_timer(input logic [ID_W-1:0] id);
    send_request(OP_CANCEL, id, wide_time(), wide_time());
  endtask

  task automatic tick_at(input tmq_time_t now_v);
    send_request(OP_TICK, ID_W'($urandom), wide_time(), now_v);
  endtask

  // The sender stops until every expected result has come, then lets the block settle.
  // The first edge is waited out because the checker's counts lag the edge by one step.
  task automatic wait_for_drain();
    req_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Result sink. For every result it draws a stall length; now and then it runs with no
  // stall at all, and once, when asked, it holds off for a long stretch so that a tick's
  // results back up and the block stalls its request channel.
  initial begin : result_sink
    int  pause;
    int  taken;
    bit  sink_fast;
    bit  hold_done;
    taken = 0;
    sink_fast = 1'b0;
    hold_done = 1'b0;
    rsp_stall <= 1'b0;
    do @(posedge clk); while (rst);
    forever begin
      if (hold_req && !hold_done) begin
        pause = LONG_HOLD;
        hold_done = 1'b1;
      end else if (sink_fast) begin
        pause = 0;
      end else begin
        pause = $urandom_range(0, 15);
      end
      if (pause > 0) begin
        rsp_stall <= 1'b1;
        repeat (pause) @(posedge clk);
      end
      rsp_stall <= 1'b0;
      do @(posedge clk); while (!(rsp_valid && !rsp_stall));
      taken++;
      if (taken % 12 == 0) sink_fast = ($urandom_range(0, 3) == 0);
    end
  end

  // Watchdog: the run ends if no transaction moves on either channel for too long.
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if (rst || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) quiet = 0;
      else quiet++;
    end
    $display("%0t: watchdog expired after %0d idle cycles", $time, WATCHDOG_LIMIT);
    $display("Test completed with failures");
    $finish;
  end

  initial begin : stimulus
    bit full_done;
    bit mid_done;
    int count;
    full_done = 1'b0;
    mid_done = 1'b0;
    stim_time = '0;
    items_sent = 0;
    no_gap = 1'b0;
    hold_req = 1'b0;
    end_check <= 1'b0;
    req_valid <= 1'b0;
    operation <= OP_ARM;
    timer_id <= '0;
    delay_ticks <= '0;
    now_time <= '0;
    rst <= 1'b1;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // Directed part. A tick with nothing armed reports no deadline.
    tick_at('0);
    // A slot armed with expiry zero is still a live timer and fires at time zero.
    arm_timer(4'd0, '0);
    arm_timer(4'd15, TIME_MAX);
    tick_at('0);
    tick_at(tmq_time_t'(1000));
    // From time 1000 the largest delay overflows and must saturate.
    arm_timer(4'd3, TIME_MAX);
    arm_timer(4'd5, tmq_time_t'(10));
    arm_timer(4'd2, tmq_time_t'(10));
    arm_timer(4'd7, tmq_time_t'(5));
    // Re-arming a queued slot only moves its deadline.
    arm_timer(4'd5, tmq_time_t'(20));
    cancel_timer(4'd7);
    // Cancel of an idle slot, then the unused operation code: neither changes anything.
    cancel_timer(4'd9);
    send_request(OP_UNUSED, 4'd6, wide_time(), wide_time());
    // Slot 5 was moved out to 1020 while slot 2 sits at 1010; only slot 2 fires here.
    tick_at(tmq_time_t'(1010));
    // Time going back is loaded but fires nothing.
    tick_at(tmq_time_t'(500));
    // The top of the range fires the rest; the two deadlines at the top of the range tie to the lower id.
    tick_at(TIME_MAX);
    arm_timer(4'd1, '0);
    tick_at(TIME_MAX - 1);
    cancel_timer(4'd1);
    tick_at('0);
    wait_for_drain();

    // Random part: mostly groups of arms followed by a tick, with raw random requests
    // mixed in. The first group arms every slot with near-equal deadlines so that one
    // tick fires all of them.
    items_sent = 0;
    while (items_sent < RANDOM_ITEMS) begin
      if (!hold_req && items_sent >= 20) hold_req = 1'b1;
      if (!mid_done && items_sent >= RANDOM_ITEMS / 2) begin
        wait_for_drain();
        mid_done = 1'b1;
      end
      no_gap = ($urandom_range(0, 3) == 0);
      if (!full_done) begin
        for (int i = 0; i < NUM_SLOTS; i++) arm_timer(ID_W'(i), tmq_time_t'($urandom_range(0, 3)));
        tick_at(later(tmq_time_t'(3)));
        full_done = 1'b1;
      end else if ($urandom_range(0, 9) < 7) begin
        count = $urandom_range(1, 6);
        repeat (count) arm_timer(ID_W'($urandom_range(0, NUM_SLOTS - 1)), pick_delay());
        if ($urandom_range(0, 1) == 1) cancel_timer(ID_W'($urandom_range(0, NUM_SLOTS - 1)));
        case ($urandom_range(0, 7))
          0:       tick_at(wide_time());
          1:       tick_at(stim_time - tmq_time_t'($urandom_range(0, 100)));
          default: tick_at(later(tmq_time_t'($urandom_range(0, 250))));
        endcase
      end else begin
        send_request(OP_W'($urandom_range(0, 3)), ID_W'($urandom), wide_time(), wide_time());
      end
    end

    // All stimulus is in: wait for the last results, then let the checker look for
    // anything still outstanding before the verdict.
    wait_for_drain();
    end_check <= 1'b1;
    repeat (2) @(posedge clk);
    $display("Run covered %0d requests with %0d ticks; %0d slots fired, up to %0d by one tick.",
             request_total, tick_total, fired_total, most_fired);
    $display("Stimulus: directed corner cases, random arm groups and raw requests under stalls.");
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// ===== timer_expiry_queue.f =====
rtl/tmq_pkg.sv
rtl/tmq_expiry_ram.sv
rtl/tmq_scan.sv
rtl/timer_expiry_queue.sv
tb/timer_expiry_queue_checker.sv
tb/timer_expiry_queue_tb.sv
